@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the design folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ design/ctcm_pkg.sv @@
// ----------------------------------------------------------------------------
// Chroma threshold and closing package
// Field widths, register codes, reset values and the result record.
// ----------------------------------------------------------------------------
package ctcm_pkg;

    // Field widths fixed by the stream format.
    localparam int RGB_W       = 8;
    localparam int COORD_W     = 10;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;

    // Register reset values and the smallest usable frame side.
    localparam int WIDTH_RESET     = 640;
    localparam int HEIGHT_RESET    = 480;
    localparam int THRESHOLD_RESET = 32;
    localparam int MIN_SIZE        = 3;

    // Depth of the result queue.
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH      = 2'd0,
        CFG_IMAGE_HEIGHT     = 2'd1,
        CFG_CHROMA_THRESHOLD = 2'd2
    } cfg_index_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic               foreground;
        logic               frame_last;
    } result_t;

endpackage

@@ design/ctcm_pixel_if.sv @@
// ----------------------------------------------------------------------------
// Pixel stream interface
// Valid/ready channel carrying one camera pixel or a drain tick.
// ----------------------------------------------------------------------------
interface ctcm_pixel_if;

    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [ctcm_pkg::RGB_W-1:0] red;
    logic [ctcm_pkg::RGB_W-1:0] green;
    logic [ctcm_pkg::RGB_W-1:0] blue;
    logic                       in_mask;

    modport source (
        output valid, opcode, red, green, blue, in_mask,
        input  ready
    );

    modport sink (
        input  valid, opcode, red, green, blue, in_mask,
        output ready
    );

endinterface

@@ design/ctcm_result_if.sv @@
// ----------------------------------------------------------------------------
// Result stream interface
// Valid/ready channel carrying one closed mask pixel with its coordinates.
// ----------------------------------------------------------------------------
interface ctcm_result_if;

    logic                         valid;
    logic                         ready;
    logic [ctcm_pkg::COORD_W-1:0] out_x;
    logic [ctcm_pkg::COORD_W-1:0] out_y;
    logic                         foreground;
    logic                         frame_last;

    modport source (
        output valid, out_x, out_y, foreground, frame_last,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, foreground, frame_last,
        output ready
    );

endinterface

@@ design/chroma_threshold_close_mask_core.sv @@
// ----------------------------------------------------------------------------
// Chroma threshold with 3x3 closing
// Thresholds RGB chroma, dilates then erodes the binary mask in raster order.
// ----------------------------------------------------------------------------
//  Channel      Direction  Contents
//  pixel_in     sink       opcode, red, green, blue, in_mask
//  result_out   source     out_x, out_y, foreground, frame_last
//  cfg_*        sink       write enable, register index, write data
//
//  One transaction per cycle is sustained on both channels while result_out
//  stays ready. A result passes the dilate and erode stages into the queue;
//  both column-indexed line RAMs are read a stage ahead, written back the next.
//  Results trail the pixels by 2*W+2 positions; drain ticks push the tail out.
//  Reset clears counters and windows and sets the configuration to its reset
//  values; line RAMs are not cleared, as every in-frame neighbour is written
//  before it is read. A four-entry result queue absorbs output stalls;
//  pixel_in.ready drops once queued plus in-flight results reach four.
// ----------------------------------------------------------------------------
module chroma_threshold_close_mask_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ctcm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ctcm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    ctcm_pixel_if.sink                       pixel_in,
    ctcm_result_if.source                    result_out
);

    `include "assert_macros.svh"

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 3);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = ctcm_pkg::COORD_W;
    localparam int RW    = ctcm_pkg::RGB_W;
    localparam int DW    = ctcm_pkg::CFG_DATA_W;
    localparam int FD    = ctcm_pkg::FIFO_DEPTH;
    localparam int PTR_W = $clog2(FD);
    localparam int CNT_W = $clog2(FD + 1);
    localparam int WIDTH_INIT  = (ctcm_pkg::WIDTH_RESET > MAX_WIDTH) ?
                                 MAX_WIDTH : ctcm_pkg::WIDTH_RESET;
    localparam int HEIGHT_INIT = (ctcm_pkg::HEIGHT_RESET > MAX_HEIGHT) ?
                                 MAX_HEIGHT : ctcm_pkg::HEIGHT_RESET;

    typedef struct packed {
        logic [YW-1:0] row;
        logic [XW-1:0] col;
    } pos_t;

    // Item entering the dilate stage.
    typedef struct packed {
        logic          valid;
        logic          t;
        logic [XW-1:0] nx;
        logic          dval;
        pos_t          dil;
        logic          emit;
        pos_t          ero;
        logic          last;
    } s1_t;

    // Item entering the erode stage.
    typedef struct packed {
        logic          valid;
        logic          d;
        logic          dval;
        logic [XW-1:0] dcx;
        logic          emit;
        pos_t          ero;
        logic          last;
    } s2_t;

    // Step a raster position by one pixel.
    function automatic pos_t advance(input pos_t p, input logic [XW-1:0] last_col);
        pos_t r;
        r = p;
        if (p.col == last_col) begin
            r.col = '0;
            r.row = p.row + YW'(1);
        end
        else begin
            r.col = p.col + XW'(1);
        end
        return r;
    endfunction

    function automatic logic [WW-1:0] clamp_width(input logic [DW-1:0] v);
        logic [WW-1:0] r;
        if (int'(v) < ctcm_pkg::MIN_SIZE) begin
            r = WW'(ctcm_pkg::MIN_SIZE);
        end
        else if (int'(v) > MAX_WIDTH) begin
            r = WW'(MAX_WIDTH);
        end
        else begin
            r = WW'(v);
        end
        return r;
    endfunction

    function automatic logic [HW-1:0] clamp_height(input logic [DW-1:0] v);
        logic [HW-1:0] r;
        if (int'(v) < ctcm_pkg::MIN_SIZE) begin
            r = HW'(ctcm_pkg::MIN_SIZE);
        end
        else if (int'(v) > MAX_HEIGHT) begin
            r = HW'(MAX_HEIGHT);
        end
        else begin
            r = HW'(v);
        end
        return r;
    endfunction

    // Configuration registers, held already clamped to the legal frame size.
    logic [WW-1:0] width_reg;
    logic [HW-1:0] height_reg;
    logic [RW-1:0] thresh_reg;

    // Raster positions of the newest pixel, the dilate center and the erode center.
    pos_t new_pos_reg, new_pos_next;
    pos_t dil_pos_reg, dil_pos_next;
    pos_t ero_pos_reg, ero_pos_next;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;

    // Line RAMs: per column, bit 1 holds the row above, bit 0 the row two above.
    logic [1:0] thr_mem [MAX_WIDTH];
    logic [1:0] dil_mem [MAX_WIDTH];
    logic [1:0] thr_rd_reg;
    logic [1:0] dil_rd_reg;

    // Two older columns of each 3x3 window; index 1 is the center column.
    logic [1:0][2:0] dwin_reg;
    logic [1:0][2:0] ewin_reg;

    // Result queue and slot reservation.
    ctcm_pkg::result_t fifo_mem [FD];
    ctcm_pkg::result_t fifo_entry;
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  fifo_count_reg, fifo_count_next;
    logic [CNT_W-1:0]  reserved_reg, reserved_next;

    logic [XW-1:0] wm1;
    logic [YW-1:0] h_ext, hm1;
    logic          in_fire, frame_done, step;
    logic [RW-1:0] hi, lo, chroma;
    logic          thr_bit, emit_s, dval_s, last_s;
    logic [2:0]    dcol_new, dmask, ecol_new, emask;
    logic          d_left_ok, d_right_ok, e_left_ok, e_right_ok, d_bit, fg_bit;
    logic          fifo_push, pop, release_slot;

    // Frame bounds in counter widths.
    assign wm1   = XW'(width_reg - WW'(1));
    assign h_ext = YW'(height_reg);
    assign hm1   = h_ext - YW'(1);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(WIDTH_INIT);
            height_reg <= HW'(HEIGHT_INIT);
            thresh_reg <= RW'(ctcm_pkg::THRESHOLD_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ctcm_pkg::CFG_IMAGE_WIDTH:      width_reg  <= clamp_width(cfg_wdata);
                ctcm_pkg::CFG_IMAGE_HEIGHT:     height_reg <= clamp_height(cfg_wdata);
                ctcm_pkg::CFG_CHROMA_THRESHOLD: thresh_reg <= cfg_wdata[RW-1:0];
                default: ;
            endcase
        end
    end

    // Input decode: a drain tick before the frame is complete does nothing.
    assign pixel_in.ready = (reserved_reg < CNT_W'(FD));
    assign in_fire        = pixel_in.valid && pixel_in.ready;
    assign frame_done     = (new_pos_reg.row >= h_ext);
    assign step           = in_fire &&
                            (frame_done || (pixel_in.opcode == ctcm_pkg::OP_PIXEL));

    // Chroma and threshold; positions past the frame feed a zero.
    always_comb
    begin
        hi = pixel_in.red;
        lo = pixel_in.red;
        if (pixel_in.green > hi) hi = pixel_in.green;
        if (pixel_in.blue > hi)  hi = pixel_in.blue;
        if (pixel_in.green < lo) lo = pixel_in.green;
        if (pixel_in.blue < lo)  lo = pixel_in.blue;
        chroma  = pixel_in.in_mask ? (hi - lo) : '0;
        thr_bit = !frame_done && (chroma <= thresh_reg);
    end

    // A dilate center exists from position W+1, a result from position 2W+2.
    assign dval_s = (new_pos_reg.row >= YW'(2)) ||
                    ((new_pos_reg.row == YW'(1)) && (new_pos_reg.col >= XW'(1)));
    assign emit_s = frame_done || (new_pos_reg.row >= YW'(3)) ||
                    ((new_pos_reg.row == YW'(2)) && (new_pos_reg.col >= XW'(2)));
    assign last_s = emit_s && (ero_pos_reg.row == hm1) && (ero_pos_reg.col == wm1);

    // Position counters; the final result of a frame restarts all of them.
    always_comb
    begin
        new_pos_next = new_pos_reg;
        dil_pos_next = dil_pos_reg;
        ero_pos_next = ero_pos_reg;
        if (step)
        begin
            if (last_s)
            begin
                new_pos_next = '0;
                dil_pos_next = '0;
                ero_pos_next = '0;
            end
            else
            begin
                new_pos_next = advance(new_pos_reg, wm1);
                if (dval_s) dil_pos_next = advance(dil_pos_reg, wm1);
                if (emit_s) ero_pos_next = advance(ero_pos_reg, wm1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            new_pos_reg <= '0;
            dil_pos_reg <= '0;
            ero_pos_reg <= '0;
        end
        else
        begin
            new_pos_reg <= new_pos_next;
            dil_pos_reg <= dil_pos_next;
            ero_pos_reg <= ero_pos_next;
        end
    end

    // Capture the accepted step for the dilate stage.
    always_comb
    begin
        s1_next.valid = step;
        s1_next.t     = thr_bit;
        s1_next.nx    = new_pos_reg.col;
        s1_next.dval  = dval_s;
        s1_next.dil   = dil_pos_reg;
        s1_next.emit  = emit_s;
        s1_next.ero   = ero_pos_reg;
        s1_next.last  = last_s;
    end

    // Threshold line RAM: read at acceptance, written back in the following cycle.
    // The same column comes back only W >= 3 steps later, so no forwarding.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            thr_rd_reg <= thr_mem[new_pos_reg.col];
        end
        if (s1_reg.valid)
        begin
            thr_mem[s1_reg.nx] <= {s1_reg.t, thr_rd_reg[1]};
        end
    end

    // Dilate: OR over the window, neighbours outside the frame ignored.
    always_comb
    begin
        dcol_new   = {s1_reg.t, thr_rd_reg[1], thr_rd_reg[0]};
        dmask      = {s1_reg.dil.row != hm1, 1'b1, s1_reg.dil.row != '0};
        d_left_ok  = (s1_reg.dil.col != '0);
        d_right_ok = (s1_reg.dil.col != wm1);
        d_bit      = (|(dwin_reg[0] & dmask & {3{d_left_ok}})) |
                     (|(dwin_reg[1] & dmask)) |
                     (|(dcol_new & dmask & {3{d_right_ok}}));

        s2_next.valid = s1_reg.valid;
        s2_next.d     = d_bit;
        s2_next.dval  = s1_reg.dval;
        s2_next.dcx   = s1_reg.dil.col;
        s2_next.emit  = s1_reg.emit;
        s2_next.ero   = s1_reg.ero;
        s2_next.last  = s1_reg.last;
    end

    // Dilated line RAM: read in the dilate stage, written back in the erode stage.
    always_ff @(posedge clk)
    begin
        if (s1_reg.valid && s1_reg.dval)
        begin
            dil_rd_reg <= dil_mem[s1_reg.dil.col];
        end
        if (s2_reg.valid && s2_reg.dval)
        begin
            dil_mem[s2_reg.dcx] <= {s2_reg.d, dil_rd_reg[1]};
        end
    end

    // Erode: AND over the window, neighbours outside the frame read as one.
    always_comb
    begin
        ecol_new   = {s2_reg.d, dil_rd_reg[1], dil_rd_reg[0]};
        emask      = {s2_reg.ero.row != hm1, 1'b1, s2_reg.ero.row != '0};
        e_left_ok  = (s2_reg.ero.col != '0);
        e_right_ok = (s2_reg.ero.col != wm1);
        fg_bit     = (&(ewin_reg[0] | ~(emask & {3{e_left_ok}}))) &
                     (&(ewin_reg[1] | ~emask)) &
                     (&(ecol_new | ~(emask & {3{e_right_ok}})));

        fifo_entry.out_x      = CW'(s2_reg.ero.col);
        fifo_entry.out_y      = CW'(s2_reg.ero.row);
        fifo_entry.foreground = fg_bit;
        fifo_entry.frame_last = s2_reg.last;
    end

    // Pipeline valid bits and window shift registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= '0;
            s2_reg   <= '0;
            dwin_reg <= '0;
            ewin_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            if (s1_reg.valid)
            begin
                dwin_reg[0] <= dwin_reg[1];
                dwin_reg[1] <= dcol_new;
            end
            if (s2_reg.valid && s2_reg.dval)
            begin
                ewin_reg[0] <= ewin_reg[1];
                ewin_reg[1] <= ecol_new;
            end
        end
    end

    // Queue; an accepted step holds a slot until its result pops or it emits none.
    assign fifo_push    = s2_reg.valid && s2_reg.emit;
    assign release_slot = s2_reg.valid && !s2_reg.emit;
    assign pop          = result_out.valid && result_out.ready;

    assign fifo_count_next = fifo_count_reg + CNT_W'(fifo_push) - CNT_W'(pop);
    assign reserved_next   = reserved_reg + CNT_W'(step) - CNT_W'(release_slot) -
                             CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (fifo_push)
        begin
            fifo_mem[wr_ptr_reg] <= fifo_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
            reserved_reg   <= '0;
        end
        else
        begin
            if (fifo_push) wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)       rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            fifo_count_reg <= fifo_count_next;
            reserved_reg   <= reserved_next;
        end
    end

    assign result_out.valid      = (fifo_count_reg != '0);
    assign result_out.out_x      = fifo_mem[rd_ptr_reg].out_x;
    assign result_out.out_y      = fifo_mem[rd_ptr_reg].out_y;
    assign result_out.foreground = fifo_mem[rd_ptr_reg].foreground;
    assign result_out.frame_last = fifo_mem[rd_ptr_reg].frame_last;

    // Reservations never exceed the queue, and queued results are always reserved.
    `ASSERT_IMPLIES(a_reserve_bound, clk, rst_n, 1'b1, reserved_reg <= CNT_W'(FD))
    `ASSERT_IMPLIES(a_queue_reserved, clk, rst_n, 1'b1, fifo_count_reg <= reserved_reg)
    // A result always has the dilated column it erodes over.
    `ASSERT_IMPLIES(a_emit_has_dilate, clk, rst_n, s2_reg.valid && s2_reg.emit, s2_reg.dval)
    // The final result of a frame restarts the raster counters.
    `ASSERT_NEXT(a_frame_restart, clk, rst_n, step && last_s, new_pos_reg == '0 && ero_pos_reg == '0)

endmodule

@@ sim/tb_chroma_threshold_close_mask_core.sv @@
// ----------------------------------------------------------------------------
// Testbench for the chroma threshold and closing core
// Streams small RGB frames and a few frames at the largest sizes through the
// core, with random gaps on the pixel side and random stalls on the result
// side. A predictor keeps its own ring of mask rows and its own counters,
// and every result is checked field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_chroma_threshold_close_mask_core;

    timeunit 1ns;
    timeprecision 1ps;

    import ctcm_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int FRAME_MAX_WIDTH  = 1024;
    localparam int FRAME_MAX_HEIGHT = 1024;
    localparam int MASK_RING_ROWS   = 6;
    localparam int MAX_WAIT         = 12;
    localparam int SETTLE_CYCLES    = 16;
    localparam int QUIET_LIMIT      = 400;
    localparam int RANDOM_ITEMS     = 700;

    typedef struct packed {
        opcode_t          opcode;
        logic [RGB_W-1:0] red;
        logic [RGB_W-1:0] green;
        logic [RGB_W-1:0] blue;
        logic             in_mask;
    } pixel_item_t;

    // One row of the directed table; no_result marks a row whose outcome is
    // known to be empty without running the predictor.
    typedef struct packed {
        pixel_item_t item;
        bit          no_result;
    } stimulus_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    ctcm_pixel_if  pixel_ch();
    ctcm_result_if result_ch();

    chroma_threshold_close_mask_core #(
        .MAX_WIDTH  (FRAME_MAX_WIDTH),
        .MAX_HEIGHT (FRAME_MAX_HEIGHT)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .pixel_in   (pixel_ch),
        .result_out (result_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predictor state: register copies, mask ring and raster counters.
    logic [CFG_DATA_W-1:0] width_reg     = CFG_DATA_W'(WIDTH_RESET);
    logic [CFG_DATA_W-1:0] height_reg    = CFG_DATA_W'(HEIGHT_RESET);
    logic [RGB_W-1:0]      threshold_reg = RGB_W'(THRESHOLD_RESET);
    bit                    mask_ring [MASK_RING_ROWS][FRAME_MAX_WIDTH];
    logic [COORD_W-1:0]    in_col  = '0;
    logic [COORD_W-1:0]    in_row  = '0;
    logic [COORD_W-1:0]    out_col = '0;
    logic [COORD_W-1:0]    out_row = '0;
    bit                    frame_in_done = 1'b0;

    result_t       closed_mask_expected [$];
    stimulus_row_t directed_rows [$];
    int unsigned   mismatch_count = 0;
    int unsigned   quiet_cycles   = 0;
    bit            send_steady    = 1'b0;
    bit            take_steady    = 1'b0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Out-of-range sizes are pulled into MIN_SIZE..max_side.
    function automatic int clamp_side(input logic [CFG_DATA_W-1:0] v, input int max_side);
        int side;
        side = int'(v);
        if (side < MIN_SIZE) side = MIN_SIZE;
        if (side > max_side) side = max_side;
        return side;
    endfunction

    function automatic bit in_frame(input int x, input int y, input int w, input int h);
        return x >= 0 && y >= 0 && x < w && y < h;
    endfunction

    // 3x3 maximum of the thresholded mask, ignoring neighbors off the image.
    function automatic bit dilated_at(input int x, input int y, input int w, input int h);
        bit hit;
        hit = 1'b0;
        for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
                if (in_frame(x + dx, y + dy, w, h))
                    hit |= mask_ring[(y + dy) % MASK_RING_ROWS][x + dx];
        return hit;
    endfunction

    // 3x3 minimum of the dilated mask, ignoring neighbors off the image.
    function automatic bit closed_at(input int x, input int y, input int w, input int h);
        bit keep;
        keep = 1'b1;
        for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
                if (in_frame(x + dx, y + dy, w, h) && !dilated_at(x + dx, y + dy, w, h))
                    keep = 1'b0;
        return keep;
    endfunction

    // Advances the predictor by one accepted transaction; returns 1 when a
    // result pixel leaves and places it in res.
    function automatic bit predict_closed_pixel(input pixel_item_t it, output result_t res);
        int     w;
        int     h;
        int     hi;
        int     lo;
        int     chroma;
        longint received;
        longint out_pos;
        bit     emit;
        bit     frame_end;
        w   = clamp_side(width_reg, FRAME_MAX_WIDTH);
        h   = clamp_side(height_reg, FRAME_MAX_HEIGHT);
        res = '0;
        if (it.opcode == OP_PIXEL && !frame_in_done) begin
            hi = int'(it.red);
            lo = int'(it.red);
            if (int'(it.green) > hi) hi = int'(it.green);
            if (int'(it.blue) > hi) hi = int'(it.blue);
            if (int'(it.green) < lo) lo = int'(it.green);
            if (int'(it.blue) < lo) lo = int'(it.blue);
            chroma = it.in_mask ? hi - lo : 0;
            mask_ring[int'(in_row) % MASK_RING_ROWS][in_col] = (chroma <= int'(threshold_reg));
            if (int'(in_col) + 1 >= w) begin
                in_col = '0;
                if (int'(in_row) + 1 >= h) begin
                    in_row        = '0;
                    frame_in_done = 1'b1;
                end
                else begin
                    in_row = in_row + 1'b1;
                end
            end
            else begin
                in_col = in_col + 1'b1;
            end
            received = frame_in_done ? longint'(w) * h : longint'(in_row) * w + in_col;
            out_pos  = longint'(out_row) * w + out_col;
            emit     = frame_in_done || received >= out_pos + 2 * w + 3;
        end
        else begin
            emit = frame_in_done;
        end
        if (emit) begin
            frame_end      = (int'(out_row) + 1 >= h) && (int'(out_col) + 1 >= w);
            res.out_x      = out_col;
            res.out_y      = out_row;
            res.foreground = closed_at(int'(out_col), int'(out_row), w, h);
            res.frame_last = frame_end;
            if (frame_end) begin
                out_col       = '0;
                out_row       = '0;
                in_col        = '0;
                in_row        = '0;
                frame_in_done = 1'b0;
            end
            else if (int'(out_col) + 1 >= w) begin
                out_col = '0;
                out_row = out_row + 1'b1;
            end
            else begin
                out_col = out_col + 1'b1;
            end
        end
        return emit;
    endfunction

    // Register write; the predictor copy changes at the same edge.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            CFG_IMAGE_WIDTH:  width_reg = data;
            CFG_IMAGE_HEIGHT: height_reg = data;
            default:          threshold_reg = data[RGB_W-1:0];
        endcase
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                             input bit write_threshold,
                             input logic [CFG_DATA_W-1:0] threshold_data);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        if (write_threshold)
            write_reg(CFG_CHROMA_THRESHOLD, threshold_data);
        cfg_we <= 1'b0;
    endtask

    // Drives one transaction after a random gap and books its expectation
    // once it is accepted.
    task automatic send_item(input pixel_item_t it, input bit no_result);
        int unsigned gap;
        result_t     predicted;
        bit          produced;
        gap = send_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 31) == 0)
            send_steady = !send_steady;
        if (gap != 0) begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_ch.valid   <= 1'b1;
        pixel_ch.opcode  <= it.opcode;
        pixel_ch.red     <= it.red;
        pixel_ch.green   <= it.green;
        pixel_ch.blue    <= it.blue;
        pixel_ch.in_mask <= it.in_mask;
        @(posedge clk);
        while (!pixel_ch.ready) @(posedge clk);
        produced = predict_closed_pixel(it, predicted);
        if (produced && !no_result)
            closed_mask_expected.push_back(predicted);
    endtask

    task automatic wait_idle();
        pixel_ch.valid <= 1'b0;
        while (closed_mask_expected.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Near-grey pixels give low chroma, free ones mostly high chroma.
    function automatic pixel_item_t random_item(input opcode_t op, input int grey_pct);
        pixel_item_t      it;
        logic [RGB_W-1:0] v;
        v         = RGB_W'($urandom_range(0, 255));
        it.opcode = op;
        if ($urandom_range(0, 99) < grey_pct) begin
            it.red   = v;
            it.green = v ^ RGB_W'($urandom_range(0, 7));
            it.blue  = v ^ RGB_W'($urandom_range(0, 7));
        end
        else begin
            it.red   = RGB_W'($urandom_range(0, 255));
            it.green = RGB_W'($urandom_range(0, 255));
            it.blue  = RGB_W'($urandom_range(0, 255));
        end
        it.in_mask = ($urandom_range(0, 4) != 0);
        return it;
    endfunction

    // One whole frame with stray drain ticks, then the flush of its tail.
    task automatic run_frame(input int grey_pct, inout int unsigned counted);
        int pixels;
        pixels = clamp_side(width_reg, FRAME_MAX_WIDTH) * clamp_side(height_reg, FRAME_MAX_HEIGHT);
        for (int n = 0; n < pixels; n++) begin
            if ($urandom_range(0, 15) == 0)
                send_item(random_item(OP_DRAIN, grey_pct), 1'b0);
            send_item(random_item(OP_PIXEL, grey_pct), 1'b0);
            counted++;
        end
        while (frame_in_done) begin
            send_item(random_item(($urandom_range(0, 4) == 0) ? OP_PIXEL : OP_DRAIN, grey_pct),
                      1'b0);
            counted++;
        end
        if ($urandom_range(0, 3) == 0)
            send_item(random_item(OP_DRAIN, grey_pct), 1'b0);
    endtask

    task automatic add_row(input opcode_t op, input logic [RGB_W-1:0] r,
                           input logic [RGB_W-1:0] g, input logic [RGB_W-1:0] b,
                           input logic m, input bit no_result);
        stimulus_row_t row;
        row.item.opcode  = op;
        row.item.red     = r;
        row.item.green   = g;
        row.item.blue    = b;
        row.item.in_mask = m;
        row.no_result    = no_result;
        directed_rows.push_back(row);
    endtask

    // Result side: random stalls, then each transaction is checked against
    // the oldest expectation.
    initial begin : result_sink
        int unsigned stall;
        result_t     got;
        result_t     want;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = take_steady ? 0 : $urandom_range(0, MAX_WAIT);
            if ($urandom_range(0, 31) == 0)
                take_steady = !take_steady;
            if (stall != 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid) @(posedge clk);
            got.out_x      = result_ch.out_x;
            got.out_y      = result_ch.out_y;
            got.foreground = result_ch.foreground;
            got.frame_last = result_ch.frame_last;
            if (closed_mask_expected.size() == 0) begin
                report_mismatch($sformatf("result at (%0d,%0d) with none expected",
                                          got.out_x, got.out_y));
            end
            else begin
                want = closed_mask_expected.pop_front();
                if (got.out_x != want.out_x)
                    report_mismatch($sformatf("out_x %0d, expected %0d", got.out_x, want.out_x));
                if (got.out_y != want.out_y)
                    report_mismatch($sformatf("out_y %0d, expected %0d", got.out_y, want.out_y));
                if (got.foreground != want.foreground)
                    report_mismatch($sformatf("foreground %0b at (%0d,%0d), expected %0b",
                                              got.foreground, want.out_x, want.out_y,
                                              want.foreground));
                if (got.frame_last != want.frame_last)
                    report_mismatch($sformatf("frame_last %0b at (%0d,%0d), expected %0b",
                                              got.frame_last, want.out_x, want.out_y,
                                              want.frame_last));
            end
        end
    end

    // Watchdog: too many cycles without any transaction or register write.
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (pixel_ch.valid && pixel_ch.ready)
            || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned      random_items;
        logic [RGB_W-1:0] thr;
        random_items = 0;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_IMAGE_WIDTH;
        cfg_wdata        <= '0;
        pixel_ch.valid   <= 1'b0;
        pixel_ch.opcode  <= OP_PIXEL;
        pixel_ch.red     <= '0;
        pixel_ch.green   <= '0;
        pixel_ch.blue    <= '0;
        pixel_ch.in_mask <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frame: sizes below the minimum clamp to 3x3, and the
        // threshold keeps its reset value.
        configure(11'd1, 11'd0, 1'b0, '0);

        // A drain tick before the frame has ended is ignored.
        add_row(OP_DRAIN, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1);
        // Nothing can leave before 2*W+3 pixels have arrived.
        add_row(OP_PIXEL, 8'd0,   8'd0,   8'd0,   1'b1, 1'b1);
        add_row(OP_PIXEL, 8'd32,  8'd0,   8'd0,   1'b1, 1'b1);
        add_row(OP_PIXEL, 8'd33,  8'd0,   8'd0,   1'b1, 1'b1);
        add_row(OP_PIXEL, 8'd0,   8'd255, 8'd0,   1'b0, 1'b1);
        add_row(OP_PIXEL, 8'd255, 8'd0,   8'd0,   1'b1, 1'b1);
        add_row(OP_PIXEL, 8'd0,   8'd0,   8'd255, 1'b1, 1'b1);
        add_row(OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
        add_row(OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
        // The last pixel completes the frame and releases the first result.
        add_row(OP_PIXEL, 8'd0,   8'd33,  8'd0,   1'b1, 1'b0);
        // Drain ticks flush the tail; a pixel after frame end acts as one.
        add_row(OP_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        add_row(OP_DRAIN, 8'h55, 8'hAA, 8'h55, 1'b1, 1'b0);
        add_row(OP_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        add_row(OP_PIXEL, 8'd255, 8'd0,   8'd255, 1'b1, 1'b0);
        add_row(OP_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        add_row(OP_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        add_row(OP_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        add_row(OP_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        // The frame has restarted, so this tick finds nothing to flush.
        add_row(OP_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].no_result);

        // Widest frame: an oversized width clamps to the line store size.
        wait_idle();
        configure(11'd2047, 11'd3, 1'b1, 11'd255);
        run_frame(50, random_items);

        // Tallest frame; the threshold write carries junk above bit 7.
        wait_idle();
        configure(11'd3, 11'd1024, 1'b1, 11'h700);
        run_frame(50, random_items);

        // Small frames with random sizes, thresholds and content.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0:       thr = '0;
                1:       thr = '1;
                default: thr = RGB_W'($urandom_range(0, 255));
            endcase
            wait_idle();
            configure(CFG_DATA_W'($urandom_range(3, 10)), CFG_DATA_W'($urandom_range(3, 8)),
                      1'b1, {3'($urandom_range(0, 7)), thr});
            repeat ($urandom_range(1, 3))
                run_frame($urandom_range(0, 100), random_items);
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
